/* hw/rtl/bmap_pkg.sv */
// Shared types and constants for the block map first-fit allocator.
`default_nettype none

package bmap_pkg;

   localparam int NUM_BLOCKS = 64;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int SIZE_W     = 32;
   localparam int BSZ_W      = 16;
   localparam int FB_W       = 22;
   localparam int FRAG_W     = 21;
   localparam int FRAG_SCALE = 100 * 256;
   localparam int DCNT_W     = $clog2(SIZE_W);

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_SET    = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      BS_RESERVED = 2'd0,
      BS_DEFECT   = 2'd1,
      BS_FREE     = 2'd2,
      BS_OCCUPIED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RC_OK      = 2'd0,
      RC_NOSPACE = 2'd1,
      RC_RANGE   = 2'd2,
      RC_SPARE   = 2'd3
   } code_type;

   typedef enum logic {
      REG_TOTAL_BLOCKS = 1'b0,
      REG_BLOCK_SIZE   = 1'b1
   } reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_SCAN,
      S_DECIDE,
      S_ALLOC,
      S_REPLY
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/block_map_first_fit_allocator_unit.sv */
// Top level of the block map first-fit allocator: status map, scan sequencer and shared divider.
//
// One command is taken at a time; busy is high from the cycle after start until the command's
// last result beat is issued. Every result beat shows on the rsp_ ports for one cycle with
// rsp_strobe and cannot be held off. Timing is set by the shared 32-step restoring divider and
// by the map scan of the blocks in use, one block per cycle through the registered map read port:
// free and set status go straight to their result beat; query scans the map, then runs the
// fragmentation divide when any block is occupied; allocate runs the block count divide, scans
// to count free blocks and decides, then either gives a single beat or runs a second scan that
// emits one allocated block per free block found until the requested count is reached. The map
// reads all free right after reset through per-block written flags, so no clearing pass is needed.
`default_nettype none

module block_map_first_fit_allocator_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_operation,
   input  wire logic [bmap_pkg::SIZE_W-1:0] req_size_bytes,
   input  wire logic [bmap_pkg::IDX_W-1:0]  req_target_block,
   input  wire logic [1:0]                  req_new_status,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_result_code,
   output logic [bmap_pkg::IDX_W-1:0]       rsp_block_index,
   output logic                             rsp_block_valid,
   output logic                             rsp_last,
   output logic [bmap_pkg::FB_W-1:0]        rsp_free_bytes,
   output logic [bmap_pkg::CNT_W-1:0]       rsp_longest_free_run,
   output logic [bmap_pkg::FRAG_W-1:0]      rsp_fragmentation_q8,
   output logic                             rsp_fragmentation_undefined,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [bmap_pkg::BSZ_W-1:0]  csr_wdata
);

   localparam int IW = bmap_pkg::IDX_W;
   localparam int CW = bmap_pkg::CNT_W;

   bmap_pkg::state_type   state_ff, state_in;
   bmap_pkg::op_type      op_ff, op_in;
   logic [IW-1:0]         tgt_ff, tgt_in;
   logic [1:0]            nst_ff, nst_in;

   logic [CW-1:0]         total_ff;
   logic [bmap_pkg::BSZ_W-1:0] bsize_ff;

   logic [1:0]            mem [bmap_pkg::NUM_BLOCKS];
   logic [bmap_pkg::NUM_BLOCKS-1:0] written_ff;
   logic                  mem_we;
   logic [IW-1:0]         mem_waddr;
   logic [1:0]            mem_wdata;

   logic [CW-1:0]         addr_ff, addr_in;
   logic                  rd_vld_ff;
   logic [IW-1:0]         rd_idx_ff;
   logic [1:0]            rd_data_ff;
   logic                  rd_ok_ff;
   logic                  issue;

   logic [CW-1:0]         nfree_ff, nfree_in;
   logic [CW-1:0]         nocc_ff, nocc_in;
   logic [CW-1:0]         run_ff, run_in;
   logic [CW-1:0]         best_ff, best_in;
   logic [CW-1:0]         k_ff, k_in;

   logic [bmap_pkg::BSZ_W-1:0]  rem_ff, rem_in;
   logic [bmap_pkg::SIZE_W-1:0] quo_ff, quo_in;
   logic [bmap_pkg::BSZ_W-1:0]  dvsr_ff, dvsr_in;
   logic [bmap_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [bmap_pkg::BSZ_W:0]    trial;
   logic                        trial_ge;

   bmap_pkg::code_type    code_ff, code_in;
   logic                  undef_ff, undef_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]            rsp_code_ff, rsp_code_in;
   logic [IW-1:0]         rsp_index_ff, rsp_index_in;
   logic                  rsp_bvalid_ff, rsp_bvalid_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [bmap_pkg::FB_W-1:0]   rsp_fb_ff, rsp_fb_in;
   logic [CW-1:0]         rsp_run_ff, rsp_run_in;
   logic [bmap_pkg::FRAG_W-1:0] rsp_frag_ff, rsp_frag_in;
   logic                  rsp_undef_ff, rsp_undef_in;

   logic [CW-1:0]         n_use;
   logic [1:0]            cur_st;
   logic                  cur_free;
   logic                  accept;
   logic [bmap_pkg::FB_W-1:0]   fb_prod;
   logic [bmap_pkg::FB_W-1:0]   frag_num;
   logic [CW-1:0]         run_next;

   assign busy   = (state_ff != bmap_pkg::S_IDLE);
   assign accept = start && !busy;
   assign n_use  = (total_ff > CW'(bmap_pkg::NUM_BLOCKS)) ? CW'(bmap_pkg::NUM_BLOCKS) : total_ff;
   assign issue  = ((state_ff == bmap_pkg::S_SCAN) || (state_ff == bmap_pkg::S_ALLOC))
                   && (addr_ff < n_use);
   assign cur_st   = rd_ok_ff ? rd_data_ff : bmap_pkg::BS_FREE;
   assign cur_free = (cur_st == bmap_pkg::BS_FREE);
   assign run_next = run_ff + CW'(1);
   assign trial    = {rem_ff, quo_ff[bmap_pkg::SIZE_W-1]};
   assign trial_ge = (trial >= {1'b0, dvsr_ff});
   assign fb_prod  = bmap_pkg::FB_W'(nfree_ff) * bmap_pkg::FB_W'(bsize_ff);
   assign frag_num = bmap_pkg::FB_W'(nfree_ff - best_ff) * bmap_pkg::FB_W'(bmap_pkg::FRAG_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= CW'(16);
         bsize_ff <= bmap_pkg::BSZ_W'(512);
      end else if (csr_we) begin
         case (bmap_pkg::reg_type'(csr_index))
            bmap_pkg::REG_TOTAL_BLOCKS: total_ff <= csr_wdata[CW-1:0];
            bmap_pkg::REG_BLOCK_SIZE:   bsize_ff <= csr_wdata;
            default:                    total_ff <= total_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (issue) begin
         rd_data_ff <= mem[addr_ff[IW-1:0]];
         rd_ok_ff   <= written_ff[addr_ff[IW-1:0]];
         rd_idx_ff  <= addr_ff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (mem_we) begin
         written_ff[mem_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bmap_pkg::S_IDLE;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= issue;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      tgt_ff       <= tgt_in;
      nst_ff       <= nst_in;
      addr_ff      <= addr_in;
      nfree_ff     <= nfree_in;
      nocc_ff      <= nocc_in;
      run_ff       <= run_in;
      best_ff      <= best_in;
      k_ff         <= k_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvsr_ff      <= dvsr_in;
      dcnt_ff      <= dcnt_in;
      code_ff      <= code_in;
      undef_ff     <= undef_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_index_ff <= rsp_index_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_fb_ff    <= rsp_fb_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_frag_ff  <= rsp_frag_in;
      rsp_undef_ff <= rsp_undef_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tgt_in        = tgt_ff;
      nst_in        = nst_ff;
      addr_in       = issue ? (addr_ff + CW'(1)) : addr_ff;
      nfree_in      = nfree_ff;
      nocc_in       = nocc_ff;
      run_in        = run_ff;
      best_in       = best_ff;
      k_in          = k_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvsr_in       = dvsr_ff;
      dcnt_in       = dcnt_ff;
      code_in       = code_ff;
      undef_in      = undef_ff;
      mem_we        = 1'b0;
      mem_waddr     = tgt_ff;
      mem_wdata     = nst_ff;
      rsp_strobe_in = 1'b0;
      rsp_code_in   = bmap_pkg::RC_OK;
      rsp_index_in  = '0;
      rsp_bvalid_in = 1'b0;
      rsp_last_in   = 1'b1;
      rsp_fb_in     = '0;
      rsp_run_in    = '0;
      rsp_frag_in   = '0;
      rsp_undef_in  = 1'b0;

      case (state_ff)
         bmap_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = bmap_pkg::op_type'(req_operation);
               tgt_in   = req_target_block;
               nst_in   = req_new_status;
               addr_in  = '0;
               nfree_in = '0;
               nocc_in  = '0;
               run_in   = '0;
               best_in  = '0;
               k_in     = '0;
               undef_in = 1'b0;
               code_in  = bmap_pkg::RC_OK;
               case (bmap_pkg::op_type'(req_operation))
                  bmap_pkg::OP_ALLOC: begin
                     rem_in   = '0;
                     quo_in   = req_size_bytes;
                     dvsr_in  = bsize_ff;
                     dcnt_in  = '1;
                     state_in = bmap_pkg::S_DIV;
                  end
                  bmap_pkg::OP_QUERY: state_in = bmap_pkg::S_SCAN;
                  default:            state_in = bmap_pkg::S_REPLY;
               endcase
            end
         end

         bmap_pkg::S_DIV: begin
            rem_in  = trial_ge ? bmap_pkg::BSZ_W'(trial - {1'b0, dvsr_ff})
                               : trial[bmap_pkg::BSZ_W-1:0];
            quo_in  = {quo_ff[bmap_pkg::SIZE_W-2:0], trial_ge};
            dcnt_in = dcnt_ff - bmap_pkg::DCNT_W'(1);
            if (dcnt_ff == '0) begin
               addr_in  = '0;
               state_in = (op_ff == bmap_pkg::OP_ALLOC) ? bmap_pkg::S_SCAN : bmap_pkg::S_REPLY;
            end
         end

         bmap_pkg::S_SCAN: begin
            if (rd_vld_ff) begin
               if (cur_free) begin
                  nfree_in = nfree_ff + CW'(1);
                  run_in   = run_next;
                  best_in  = (run_next > best_ff) ? run_next : best_ff;
               end else begin
                  nocc_in = nocc_ff + CW'(1);
                  run_in  = '0;
               end
            end else if (!issue) begin
               if (op_ff == bmap_pkg::OP_ALLOC) begin
                  state_in = bmap_pkg::S_DECIDE;
               end else if (nocc_ff == '0) begin
                  undef_in = 1'b1;
                  state_in = bmap_pkg::S_REPLY;
               end else begin
                  rem_in   = '0;
                  quo_in   = bmap_pkg::SIZE_W'(frag_num);
                  dvsr_in  = bmap_pkg::BSZ_W'(nocc_ff);
                  dcnt_in  = '1;
                  state_in = bmap_pkg::S_DIV;
               end
            end
         end

         bmap_pkg::S_DECIDE: begin
            addr_in = '0;
            if ((bsize_ff == '0) || (quo_ff > bmap_pkg::SIZE_W'(nfree_ff))) begin
               code_in  = bmap_pkg::RC_NOSPACE;
               state_in = bmap_pkg::S_REPLY;
            end else if (quo_ff == '0) begin
               code_in  = bmap_pkg::RC_OK;
               state_in = bmap_pkg::S_REPLY;
            end else begin
               state_in = bmap_pkg::S_ALLOC;
            end
         end

         bmap_pkg::S_ALLOC: begin
            if (rd_vld_ff && cur_free) begin
               mem_we        = 1'b1;
               mem_waddr     = rd_idx_ff;
               mem_wdata     = bmap_pkg::BS_OCCUPIED;
               k_in          = k_ff + CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_index_in  = rd_idx_ff;
               rsp_bvalid_in = 1'b1;
               rsp_last_in   = ((k_ff + CW'(1)) == quo_ff[CW-1:0]);
               if (rsp_last_in) begin
                  state_in = bmap_pkg::S_IDLE;
               end
            end else if (!rd_vld_ff && !issue) begin
               state_in = bmap_pkg::S_IDLE;
            end
         end

         bmap_pkg::S_REPLY: begin
            rsp_strobe_in = 1'b1;
            state_in      = bmap_pkg::S_IDLE;
            case (op_ff)
               bmap_pkg::OP_ALLOC: rsp_code_in = code_ff;
               bmap_pkg::OP_QUERY: begin
                  rsp_fb_in    = fb_prod;
                  rsp_run_in   = best_ff;
                  rsp_frag_in  = undef_ff ? '0 : quo_ff[bmap_pkg::FRAG_W-1:0];
                  rsp_undef_in = undef_ff;
               end
               default: begin
                  if (CW'(tgt_ff) >= n_use) begin
                     rsp_code_in = bmap_pkg::RC_RANGE;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = (op_ff == bmap_pkg::OP_FREE) ? bmap_pkg::BS_FREE : nst_ff;
                  end
               end
            endcase
         end

         default: state_in = bmap_pkg::S_IDLE;
      endcase
   end

   assign rsp_strobe                  = rsp_strobe_ff;
   assign rsp_result_code             = rsp_code_ff;
   assign rsp_block_index             = rsp_index_ff;
   assign rsp_block_valid             = rsp_bvalid_ff;
   assign rsp_last                    = rsp_last_ff;
   assign rsp_free_bytes              = rsp_fb_ff;
   assign rsp_longest_free_run        = rsp_run_ff;
   assign rsp_fragmentation_q8        = rsp_frag_ff;
   assign rsp_fragmentation_undefined = rsp_undef_ff;

endmodule

`default_nettype wire

/* hw/rtl/bmap_checker.sv */
// Port-level checks for the block map first-fit allocator, bound to the top level.
`default_nettype none

module bmap_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_strobe,
   input wire logic [1:0]                  rsp_result_code,
   input wire logic                        rsp_block_valid,
   input wire logic                        rsp_last,
   input wire logic [bmap_pkg::FB_W-1:0]   rsp_free_bytes,
   input wire logic [bmap_pkg::FRAG_W-1:0] rsp_fragmentation_q8,
   input wire logic                        rsp_fragmentation_undefined
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a command beat");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("result beat right after a last beat");

   a_alloc_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_block_valid) |->
         (rsp_result_code == bmap_pkg::RC_OK && rsp_free_bytes == '0))
      else $error("allocated block beat with error code or statistics");

   a_only_alloc_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> rsp_block_valid)
      else $error("non-final beat that carries no block");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_fragmentation_undefined) |-> (rsp_fragmentation_q8 == '0))
      else $error("fragmentation nonzero while undefined");

endmodule

bind block_map_first_fit_allocator_unit bmap_checker u_bmap_checker (
   .clock                       (clock),
   .reset                       (reset),
   .start                       (start),
   .busy                        (busy),
   .rsp_strobe                  (rsp_strobe),
   .rsp_result_code             (rsp_result_code),
   .rsp_block_valid             (rsp_block_valid),
   .rsp_last                    (rsp_last),
   .rsp_free_bytes              (rsp_free_bytes),
   .rsp_fragmentation_q8        (rsp_fragmentation_q8),
   .rsp_fragmentation_undefined (rsp_fragmentation_undefined)
);

`default_nettype wire
